@@ rtl/cmrms_pkg.sv @@
// Shared types and constants of the centered moving RMS block.
`timescale 1ns / 1ps

package cmrms_pkg;

  localparam int DATA_W    = 16;  // Q1.15 amplitude
  localparam int GAIN_W    = 16;  // Q4.12 gain
  localparam int GAIN_FRAC = 12;
  localparam int GAINED_W  = 20;  // scaled amplitude before saturation
  localparam int SQ_W      = 32;  // square of a scaled amplitude
  localparam int SUM_W     = 39;  // window sum of up to 126 squares
  localparam int WIN_W     = 7;
  localparam int WIN_LIMIT = 126;
  localparam int PS_W      = 7;   // saturating count of points in the run
  localparam int ROOT_W    = 16;

  localparam logic [GAIN_FRAC-1:0] ROUND_HALF = GAIN_FRAC'(1 << (GAIN_FRAC - 1));

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              is_final;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] rms;
    logic              last_of_run;
  } out_t;

endpackage

@@ rtl/cmrms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cmrms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/centered_moving_rms.sv @@
// Top level of the centered moving RMS smoother for one channel.
`timescale 1ns / 1ps

// Each input transaction carries one point's RMS amplitude (Q1.15) and a flag
// that marks the channel's final point. The amplitude is scaled by the Q4.12
// gain with round-half-up and saturation, squared, and stored in a ring of
// MAX_WINDOW squares. For point i the block returns floor(sqrt(floor(S / W)))
// where S sums the W squares of points i-W/2+1 .. i+(W-W/2); the first point's
// square stands in before the start of the run and the newest square past its
// end. A result therefore leaves when point i+(W-W/2) arrives, and the final
// point flushes every pending result (up to W-W/2+1 of them), the last one
// flagged with last_of_run. W is the window_length register clamped to
// 1 .. min(126, MAX_WINDOW), a zero counting as one. An input point is scaled
// in S_GAIN and squared and stored in S_SQUARE. Each result then passes the
// window gather on the ring's single read port, a drain of the registered
// read, a bit-serial restoring divider and a two-bits-per-step square root,
// and is then handed into the output register. A new input transaction is
// taken once every result of the previous point has been handed to the
// output register. The output register lets the next result be computed
// while one waits to be taken. The ring is not cleared after reset; the
// window never reads an entry that the current run has not written.
// Configuration must be written only while no point is in flight.

module centered_moving_rms
  import cmrms_pkg::*;
#(
  parameter int MAX_WINDOW = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int SLOT_SUM_W = IDX_W + 1;
  localparam int W_CAP      = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;

  localparam logic [WIN_W-1:0] DIV_LAST  = WIN_W'(SUM_W - 1);
  localparam logic [WIN_W-1:0] SQRT_LAST = WIN_W'(ROOT_W - 1);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_GAIN     = 8'b0000_0010,
    S_SQUARE   = 8'b0000_0100,
    S_ACC      = 8'b0000_1000,
    S_ACC_LAST = 8'b0001_0000,
    S_DIV      = 8'b0010_0000,
    S_SQRT     = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [WIN_W-1:0]  win_len_q;
  logic [GAIN_W-1:0] gain_q;

  // Run bookkeeping.
  logic [PS_W-1:0]  ps_q, ps_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [SQ_W-1:0]  first_sq_q;
  logic             fin_q;
  logic [WIN_W-1:0] lag_q, lag_d;

  // Datapath registers.
  logic [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0] gained_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [WIN_W-1:0]  cnt_q, cnt_d;
  logic              rd_valid_q;
  logic              use_first_q;
  logic [WIN_W-1:0]  div_rem_q, div_rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W:0]   srem_q, srem_d;

  // Output register.
  logic out_valid_q;
  out_t out_data_q;

  // Effective window and its split around the output point.
  logic [WIN_W-1:0] w_eff;
  logic [WIN_W-1:0] w_before;
  logic [WIN_W-1:0] after;

  always_comb begin
    if (win_len_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (win_len_q > WIN_W'(W_CAP)) begin
      w_eff = WIN_W'(W_CAP);
    end else begin
      w_eff = win_len_q;
    end
    w_before = w_eff >> 1;
    after    = w_eff - w_before;
  end

  // Gain stage: round half up, then saturate to full scale.
  logic [2*DATA_W-1:0] prod;
  logic [GAINED_W-1:0] gained_raw;
  logic [DATA_W-1:0]   gained_sat;

  assign prod       = sample_q * gain_q + (2 * DATA_W)'(ROUND_HALF);
  assign gained_raw = prod[2*DATA_W-1:GAIN_FRAC];
  assign gained_sat = (gained_raw[GAINED_W-1:DATA_W] != '0) ? '1 : gained_raw[DATA_W-1:0];

  logic [SQ_W-1:0] square;
  assign square = gained_q * gained_q;

  logic [PS_W-1:0] ps_inc;
  assign ps_inc = (ps_q == '1) ? ps_q : ps_q + PS_W'(1);

  logic [IDX_W-1:0] head_inc;
  assign head_inc = (head_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_q + IDX_W'(1);

  // Window addressing: distance back from the newest point, clamped at zero.
  logic [WIN_W:0]        reach;
  logic [WIN_W-1:0]      back;
  logic                  use_first;
  logic [WIN_W-1:0]      back_m;
  logic [SLOT_SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0]      rd_addr;

  always_comb begin
    reach = {1'b0, lag_q} + {1'b0, w_before};
    if (reach > {1'b0, cnt_q}) begin
      back = WIN_W'(reach - {1'b0, cnt_q} - (WIN_W + 1)'(1));
    end else begin
      back = '0;
    end
    use_first = (back >= ps_q);
    back_m    = use_first ? '0 : back;
    slot_sum  = {1'b0, head_q} + SLOT_SUM_W'(MAX_WINDOW - 1) - SLOT_SUM_W'(back_m);
    if (slot_sum >= SLOT_SUM_W'(MAX_WINDOW)) begin
      rd_addr = IDX_W'(slot_sum - SLOT_SUM_W'(MAX_WINDOW));
    end else begin
      rd_addr = IDX_W'(slot_sum);
    end
  end

  logic [SQ_W-1:0] rd_data;

  cmrms_ram #(
    .WIDTH(SQ_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == S_SQUARE),
    .waddr_i(head_q),
    .wdata_i(square),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // One quotient bit per cycle; sum_q doubles as the dividend shift register.
  logic [WIN_W:0] div_trial;
  logic           div_bit;

  assign div_trial = {div_rem_q, sum_q[SUM_W-1]};
  assign div_bit   = (div_trial >= {1'b0, w_eff});

  // Two radicand bits per cycle, taken from the top of the quotient.
  logic [ROOT_W+2:0] sq_trial;
  logic [ROOT_W+2:0] sq_sub;
  logic              sq_bit;

  assign sq_trial = {srem_q, sum_q[SQ_W-1:SQ_W-2]};
  assign sq_sub   = {1'b0, root_q, 2'b01};
  assign sq_bit   = (sq_trial >= sq_sub);

  logic out_free;
  logic out_load;
  logic last_now;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_now = fin_q && (lag_q == '0);
  assign out_load = (state_q == S_DONE) && out_free;

  logic in_accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    ps_d      = ps_q;
    head_d    = head_q;
    lag_d     = lag_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    div_rem_d = div_rem_q;
    root_d    = root_q;
    srem_d    = srem_q;

    if (rd_valid_q) begin
      sum_d = sum_q + SUM_W'(use_first_q ? first_sq_q : rd_data);
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        state_d = S_SQUARE;
      end
      S_SQUARE: begin
        ps_d   = ps_inc;
        head_d = head_inc;
        cnt_d  = '0;
        sum_d  = '0;
        if (fin_q) begin
          lag_d   = (ps_inc > after) ? after : ps_inc - PS_W'(1);
          state_d = S_ACC;
        end else if (ps_inc > after) begin
          lag_d   = after;
          state_d = S_ACC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_ACC: begin
        if (cnt_q == w_eff - WIN_W'(1)) begin
          state_d = S_ACC_LAST;
        end else begin
          cnt_d = cnt_q + WIN_W'(1);
        end
      end
      S_ACC_LAST: begin
        cnt_d     = '0;
        div_rem_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        sum_d     = {sum_q[SUM_W-2:0], div_bit};
        div_rem_d = div_bit ? WIN_W'(div_trial - {1'b0, w_eff}) : div_trial[WIN_W-1:0];
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          root_d  = '0;
          srem_d  = '0;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + WIN_W'(1);
        end
      end
      S_SQRT: begin
        sum_d  = {sum_q[SUM_W-1:SQ_W], sum_q[SQ_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], sq_bit};
        srem_d = sq_bit ? (ROOT_W + 1)'(sq_trial - sq_sub) : sq_trial[ROOT_W:0];
        if (cnt_q == SQRT_LAST) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + WIN_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (fin_q && (lag_q != '0)) begin
            lag_d   = lag_q - WIN_W'(1);
            cnt_d   = '0;
            sum_d   = '0;
            state_d = S_ACC;
          end else begin
            if (fin_q) begin
              // The run ends here; the next point starts a fresh one.
              ps_d   = '0;
              head_d = '0;
            end
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      win_len_q   <= WIN_W'(64);
      gain_q      <= GAIN_W'(4096);
      ps_q        <= '0;
      head_q      <= '0;
      first_sq_q  <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ps_q       <= ps_d;
      head_q     <= head_d;
      rd_valid_q <= (state_q == S_ACC);
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_LENGTH: win_len_q <= cfg_wdata_i[WIN_W-1:0];
          REG_LINEAR_GAIN:   gain_q    <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if ((state_q == S_SQUARE) && (ps_q == '0)) begin
        first_sq_q <= square;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= in_data_i.sample;
      fin_q    <= in_data_i.is_final;
    end
    if (state_q == S_GAIN) begin
      gained_q <= gained_sat;
    end
    lag_q       <= lag_d;
    sum_q       <= sum_d;
    cnt_q       <= cnt_d;
    use_first_q <= use_first;
    div_rem_q   <= div_rem_d;
    root_q      <= root_d;
    srem_q      <= srem_d;
    if (out_load) begin
      out_data_q.rms         <= root_q;
      out_data_q.last_of_run <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The divider remainder stays below the window length throughout the root.
  a_div_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (div_rem_q < w_eff))
    else $error("divider remainder not below window length");

  // Handing over the last result of a run clears the run bookkeeping.
  a_run_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_now) |=> ((ps_q == '0) && (head_q == '0) && (state_q == S_IDLE)))
    else $error("run state not cleared after last result");

  // The divider starts only after the window gather has drained.
  a_div_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && (cnt_q == '0)) |-> ($past(state_q) == S_ACC_LAST))
    else $error("divider entered without a completed window sum");

  // A loaded result is presented in the following cycle.
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && (out_data_o.rms == $past(root_q))))
    else $error("result not presented after load");

endmodule
